### hw/rtl/dmc_pkg.sv
// Shared constants, types and helper functions for the maze carver.
package dmc_pkg;

    // Grid and stack geometry
    localparam int GRID_SIZE   = 15;
    localparam int STACK_DEPTH = 64;

    // Coordinate, stack address and stack pointer widths
    localparam int CW  = $clog2(GRID_SIZE);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    // Port field widths
    localparam int CMD_W   = 2;
    localparam int FLD_W   = 4;
    localparam int RND_W   = 15;
    localparam int DEPTH_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_START = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_IDLE  = 2'd3
    } t_cmd;

    // Neighbor directions, in search order
    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        RD_UP   = 2'd0,
        RD_MID  = 2'd1,
        RD_DOWN = 2'd2,
        RD_CELL = 2'd3
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_START = 2'd1,
        WR_MID   = 2'd2,
        WR_TGT   = 2'd3
    } t_wr_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_START,
        S_RD_UP,
        S_RD_MID,
        S_RD_DOWN,
        S_EVAL,
        S_APPLY,
        S_CARVE_TGT,
        S_POP_LOAD,
        S_CELL_A,
        S_CELL_B,
        S_DONE
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    clear_grid;
        t_rd_sel rd_sel;
        logic    cap_up;
        logic    cap_mid;
        logic    eval;
        t_wr_sel wr_sel;
        logic    push_start;
        logic    push_tgt;
        logic    pop;
        logic    pop_load;
        logic    cap_cell;
        logic    result;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic stack_empty;
        logic do_carve;
    } t_dp_sts;

    // Remainder by three: sum base-4 digits twice, then fold
    function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
        logic [15:0] p;
        logic [4:0]  s;
        logic [2:0]  t;
        p = {1'b0, v};
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + 5'(p[2*k +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // Direction of the idx-th set candidate bit
    function automatic t_dir pick_dir(input logic [3:0] cand, input logic [1:0] idx);
        logic [1:0] n;
        t_dir       d;
        n = '0;
        d = DIR_UP;
        for (int k = 0; k < 4; k++) begin
            if (cand[k]) begin
                if (n == idx) begin
                    d = t_dir'(2'(k));
                end
                n = n + 2'd1;
            end
        end
        return d;
    endfunction

endpackage

### hw/rtl/dfs_maze_carver_core.sv
// Top level of the depth-first maze carver: controller plus datapath.
//
//  chan  dir  handshake                  fields
//  in    in   i_in_valid / o_in_stall    command row column random_value
//  out   out  o_out_valid / i_out_stall  cell_open top_row top_column carved finished stack_depth
//
// One item at a time; a step beat runs three registered row reads, a pick, and then either
// two grid writes or a stack pop read; a start clears the grid and pushes the start cell, a
// read fetches one grid row, and an idle command or a step on an empty stack goes to the result.
// Reset (synchronous, i_rst_n low) empties the stack and marks every grid row as wall.
// A new beat is accepted while the previous result still waits; under output stall
// the item holds in its final state until the result register frees up.
module dfs_maze_carver_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [dmc_pkg::CMD_W-1:0]   i_command,
    input  logic [dmc_pkg::FLD_W-1:0]   i_row,
    input  logic [dmc_pkg::FLD_W-1:0]   i_column,
    input  logic [dmc_pkg::RND_W-1:0]   i_random_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_cell_open,
    output logic [dmc_pkg::FLD_W-1:0]   o_top_row,
    output logic [dmc_pkg::FLD_W-1:0]   o_top_column,
    output logic                        o_carved,
    output logic                        o_finished,
    output logic [dmc_pkg::DEPTH_W-1:0] o_stack_depth
);
    import dmc_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    dmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // Grid, stack and result datapath
    dmc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_command      (i_command),
        .i_row          (i_row),
        .i_column       (i_column),
        .i_random_value (i_random_value),
        .o_cell_open    (o_cell_open),
        .o_top_row      (o_top_row),
        .o_top_column   (o_top_column),
        .o_carved       (o_carved),
        .o_finished     (o_finished),
        .o_stack_depth  (o_stack_depth)
    );

endmodule

### hw/rtl/dmc_ctrl.sv
// Sequencing state machine for the maze carver.
module dmc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output dmc_pkg::t_dp_cmd o_cmd,
    input  dmc_pkg::t_dp_sts i_sts
);
    import dmc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Advance state and output beat flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_START: n_state = S_START;
                    CMD_STEP:  n_state = i_sts.stack_empty ? S_DONE : S_RD_UP;
                    CMD_READ:  n_state = S_CELL_A;
                    CMD_IDLE:  n_state = S_DONE;
                    default:   n_state = S_DONE;
                endcase
            end
            S_START:     n_state = S_DONE;
            S_RD_UP:     n_state = S_RD_MID;
            S_RD_MID:    n_state = S_RD_DOWN;
            S_RD_DOWN:   n_state = S_EVAL;
            S_EVAL:      n_state = S_APPLY;
            S_APPLY:     n_state = i_sts.do_carve ? S_CARVE_TGT : S_POP_LOAD;
            S_CARVE_TGT: n_state = S_DONE;
            S_POP_LOAD:  n_state = S_DONE;
            S_CELL_A:    n_state = S_CELL_B;
            S_CELL_B:    n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    // Datapath commands and output beat flag
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RD_MID;
        o_cmd.wr_sel = WR_NONE;
        n_out_valid  = r_out_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
            end
            S_START: begin
                o_cmd.clear_grid = 1'b1;
                o_cmd.wr_sel     = WR_START;
                o_cmd.push_start = 1'b1;
            end
            S_RD_UP: begin
                o_cmd.rd_sel = RD_UP;
            end
            S_RD_MID: begin
                o_cmd.rd_sel = RD_MID;
                o_cmd.cap_up = 1'b1;
            end
            S_RD_DOWN: begin
                o_cmd.rd_sel  = RD_DOWN;
                o_cmd.cap_mid = 1'b1;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            S_APPLY: begin
                o_cmd.wr_sel = i_sts.do_carve ? WR_MID : WR_NONE;
                o_cmd.pop    = !i_sts.do_carve;
            end
            S_CARVE_TGT: begin
                o_cmd.wr_sel   = WR_TGT;
                o_cmd.push_tgt = 1'b1;
            end
            S_POP_LOAD: begin
                o_cmd.pop_load = 1'b1;
            end
            S_CELL_A: begin
                o_cmd.rd_sel = RD_CELL;
            end
            S_CELL_B: begin
                o_cmd.cap_cell = 1'b1;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.result = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

### hw/rtl/dmc_dp.sv
// Datapath: grid row memory, coordinate stack, candidate logic and result register.
module dmc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dmc_pkg::t_dp_cmd            i_cmd,
    output dmc_pkg::t_dp_sts            o_sts,
    input  logic [dmc_pkg::CMD_W-1:0]   i_command,
    input  logic [dmc_pkg::FLD_W-1:0]   i_row,
    input  logic [dmc_pkg::FLD_W-1:0]   i_column,
    input  logic [dmc_pkg::RND_W-1:0]   i_random_value,
    output logic                        o_cell_open,
    output logic [dmc_pkg::FLD_W-1:0]   o_top_row,
    output logic [dmc_pkg::FLD_W-1:0]   o_top_column,
    output logic                        o_carved,
    output logic                        o_finished,
    output logic [dmc_pkg::DEPTH_W-1:0] o_stack_depth
);
    import dmc_pkg::*;

    // Latched item fields
    t_cmd             r_cmd;
    logic [FLD_W-1:0] r_row_in;
    logic [FLD_W-1:0] r_col_in;
    logic [1:0]       r_rnd;
    logic [1:0]       r_rnd_m3;

    // Search state
    logic [CW-1:0]  r_top_r;
    logic [CW-1:0]  r_top_c;
    logic [SPW-1:0] r_sp;
    logic [3:0]     r_cand;
    t_dir           r_dir;
    logic           r_do_carve;
    logic           r_carved;
    logic           r_cell_bit;

    // Grid rows with per-row valid bits, and the coordinate stack
    logic [GRID_SIZE-1:0] r_grid [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_row_vld;
    logic [GRID_SIZE-1:0] r_rd_data;
    logic [2*CW-1:0]      r_stk [STACK_DEPTH];
    logic [2*CW-1:0]      r_stk_q;

    logic          start_ok, cell_ok;
    logic          up_ok, dn_ok, lf_ok, rt_ok;
    logic [CW-1:0] up_r, dn_r, lf_c, rt_c;
    logic [CW-1:0] rd_addr;
    logic          rd_hit;
    logic          dn_bit;
    logic [3:0]    cand_full;
    logic [2:0]    cand_cnt;
    logic [1:0]    pick_idx;
    logic          room;
    logic [CW-1:0] mid_r, mid_c, tgt_r, tgt_c;
    logic          wr_en, full_wr;
    logic [CW-1:0] wr_r, wr_c;
    logic [SAW-1:0] push_idx, stk_rd_a;
    logic [2*CW-1:0] push_data;
    logic          push_en;

    // Range checks on item coordinates and neighbors
    assign start_ok = (int'(r_row_in) < GRID_SIZE) && (int'(r_col_in) < GRID_SIZE);
    assign cell_ok  = start_ok;
    assign up_ok    = (r_top_r >= CW'(2));
    assign dn_ok    = (int'(r_top_r) + 2 < GRID_SIZE);
    assign lf_ok    = (r_top_c >= CW'(2));
    assign rt_ok    = (int'(r_top_c) + 2 < GRID_SIZE);
    assign up_r     = r_top_r - CW'(2);
    assign dn_r     = r_top_r + CW'(2);
    assign lf_c     = r_top_c - CW'(2);
    assign rt_c     = r_top_c + CW'(2);

    // Select the row to read
    always_comb begin
        case (i_cmd.rd_sel)
            RD_UP:   rd_addr = up_r;
            RD_MID:  rd_addr = r_top_r;
            RD_DOWN: rd_addr = dn_r;
            RD_CELL: rd_addr = CW'(r_row_in);
            default: rd_addr = r_top_r;
        endcase
    end
    assign rd_hit = (int'(rd_addr) < GRID_SIZE) && r_row_vld[rd_addr];

    // Candidate set with the down neighbor from the current read
    assign dn_bit    = dn_ok ? !r_rd_data[r_top_c] : 1'b0;
    assign cand_full = {r_cand[DIR_RIGHT], r_cand[DIR_LEFT], dn_bit, r_cand[DIR_UP]};
    assign cand_cnt  = 3'(cand_full[0]) + 3'(cand_full[1]) + 3'(cand_full[2])
                     + 3'(cand_full[3]);
    assign room      = (int'(r_sp) < STACK_DEPTH);

    // Choice index: random value mod candidate count
    always_comb begin
        case (cand_cnt)
            3'd2:    pick_idx = {1'b0, r_rnd[0]};
            3'd3:    pick_idx = r_rnd_m3;
            3'd4:    pick_idx = r_rnd[1:0];
            default: pick_idx = 2'd0;
        endcase
    end

    // Wall between and target cell for the chosen direction
    always_comb begin
        mid_r = r_top_r;
        mid_c = r_top_c;
        tgt_r = r_top_r;
        tgt_c = r_top_c;
        unique case (r_dir)
            DIR_UP: begin
                mid_r = r_top_r - CW'(1);
                tgt_r = up_r;
            end
            DIR_DOWN: begin
                mid_r = r_top_r + CW'(1);
                tgt_r = dn_r;
            end
            DIR_LEFT: begin
                mid_c = r_top_c - CW'(1);
                tgt_c = lf_c;
            end
            DIR_RIGHT: begin
                mid_c = r_top_c + CW'(1);
                tgt_c = rt_c;
            end
            default: begin
                mid_r = r_top_r;
            end
        endcase
    end

    // Grid write port
    always_comb begin
        wr_en = 1'b0;
        wr_r  = CW'(r_row_in);
        wr_c  = CW'(r_col_in);
        case (i_cmd.wr_sel)
            WR_START: wr_en = start_ok;
            WR_MID: begin
                wr_en = 1'b1;
                wr_r  = mid_r;
                wr_c  = mid_c;
            end
            WR_TGT: begin
                wr_en = 1'b1;
                wr_r  = tgt_r;
                wr_c  = tgt_c;
            end
            default: wr_en = 1'b0;
        endcase
    end
    assign full_wr = (i_cmd.wr_sel == WR_START) || !r_row_vld[wr_r];

    // Stack ports
    assign push_en   = (i_cmd.push_start && start_ok) || i_cmd.push_tgt;
    assign push_idx  = i_cmd.push_start ? '0 : r_sp[SAW-1:0];
    assign push_data = i_cmd.push_start ? {CW'(r_row_in), CW'(r_col_in)} : {tgt_r, tgt_c};
    assign stk_rd_a  = SAW'(r_sp - SPW'(2));

    // Grid memory: masked write, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int j = 0; j < GRID_SIZE; j++) begin
                if (full_wr || (CW'(j) == wr_c)) begin
                    r_grid[wr_r][j] <= (CW'(j) == wr_c);
                end
            end
        end
        r_rd_data <= rd_hit ? r_grid[rd_addr] : '0;
    end

    // Stack memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stk[push_idx] <= push_data;
        end
        r_stk_q <= r_stk[stk_rd_a];
    end

    // Control state: row valid bits and stack pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_sp      <= '0;
        end else begin
            // Clear all rows on start, keeping only the row just written
            if (i_cmd.clear_grid) begin
                r_row_vld <= wr_en ? (GRID_SIZE'(1) << wr_r) : '0;
            end else if (wr_en) begin
                r_row_vld[wr_r] <= 1'b1;
            end
            if (i_cmd.push_start) begin
                r_sp <= start_ok ? SPW'(1) : '0;
            end else if (i_cmd.push_tgt) begin
                r_sp <= r_sp + SPW'(1);
            end else if (i_cmd.pop) begin
                r_sp <= r_sp - SPW'(1);
            end
        end
    end

    // Item fields, candidates, choice and stack top
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= t_cmd'(i_command);
            r_row_in <= i_row;
            r_col_in <= i_column;
            r_rnd    <= i_random_value[1:0];
            r_rnd_m3 <= mod3(i_random_value);
            r_carved <= 1'b0;
        end
        if (i_cmd.cap_up) begin
            r_cand[DIR_UP] <= up_ok ? !r_rd_data[r_top_c] : 1'b0;
        end
        if (i_cmd.cap_mid) begin
            r_cand[DIR_LEFT]  <= lf_ok ? !r_rd_data[lf_c] : 1'b0;
            r_cand[DIR_RIGHT] <= rt_ok ? !r_rd_data[rt_c] : 1'b0;
        end
        if (i_cmd.eval) begin
            r_cand[DIR_DOWN] <= dn_bit;
            r_dir            <= pick_dir(cand_full, pick_idx);
            r_do_carve       <= (cand_cnt != 3'd0) && room;
        end
        if (i_cmd.push_start && start_ok) begin
            r_top_r <= CW'(r_row_in);
            r_top_c <= CW'(r_col_in);
        end else if (i_cmd.push_tgt) begin
            r_top_r  <= tgt_r;
            r_top_c  <= tgt_c;
            r_carved <= 1'b1;
        end else if (i_cmd.pop_load) begin
            r_top_r <= r_stk_q[2*CW-1:CW];
            r_top_c <= r_stk_q[CW-1:0];
        end
        if (i_cmd.cap_cell) begin
            r_cell_bit <= cell_ok && r_rd_data[CW'(r_col_in)];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.result) begin
            o_cell_open   <= (r_cmd == CMD_READ) && r_cell_bit;
            o_top_row     <= (r_sp != '0) ? FLD_W'(r_top_r) : '0;
            o_top_column  <= (r_sp != '0) ? FLD_W'(r_top_c) : '0;
            o_carved      <= (r_cmd == CMD_STEP) && r_carved;
            o_finished    <= (r_sp == '0);
            o_stack_depth <= DEPTH_W'(r_sp);
        end
    end

    assign o_sts.cmd         = r_cmd;
    assign o_sts.stack_empty = (r_sp == '0);
    assign o_sts.do_carve    = r_do_carve;

endmodule
